[hdl/fsa_pkg.sv]
// shared types and constants of the fixed slot allocator
package fsa_pkg;

	localparam int SLOTS_DEF = 64;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic wr_en;
		logic wr_val;
		logic scan;
	} cell_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOOK = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

endpackage

[hdl/fsa_cell.sv]
// one slot cell: used flag, address match and search token stage
module fsa_cell import fsa_pkg::*; #(
	parameter int IdxW = 6,
	parameter int Idx  = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cell_ctl_t       ctl,
	input  logic [IdxW-1:0] addr,
	input  logic            tok_in,
	output logic            tok_out,
	output logic            hit,
	output logic            take
);

	logic flag_q;
	logic tok_q;
	logic match;

	assign match   = (addr == IdxW'(Idx));
	assign hit     = match & flag_q;
	assign take    = ctl.scan & tok_in & ~flag_q;
	assign tok_out = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
			tok_q  <= 1'b0;
		end else begin
			if (ctl.wr_en && match) begin
				flag_q <= ctl.wr_val;
			end else if (take) begin
				flag_q <= 1'b1;
			end
			// token moves on past a used slot
			tok_q <= ctl.scan & tok_in & flag_q;
		end
	end

endmodule

[hdl/fixed_slot_allocator_core.sv]
// top level of the fixed slot allocator: control, count and the row of slot cells
//
// Command channel (cmd_valid/cmd_stall): cmd selects allocate or free, slot_index
// names the slot to free. Response channel (rsp_valid/rsp_stall): one response
// item per command with granted, slot, used_count, is_full, is_empty, bad_free.
// An item is taken at an edge with valid high and stall low.
// When the allocate finds the slot equal to the count free, or for a free or a
// failed allocate, the command passes ST_LOOK and ST_FIN to the output register.
// Otherwise a token walks the cell row one slot per cycle from slot 0 in ST_SCAN
// and stops at the lowest free slot, which is granted, before ST_FIN.
// The block takes one command at a time: the next command is accepted the cycle
// after the response is loaded into the output register.
// When the receiver stalls, the response holds in the output register and a
// finished command waits until the register frees; a new command may be
// accepted while the previous response is still waiting.
// Reset clears every used flag and the count: all slots free.
module fixed_slot_allocator_core import fsa_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int IdxW = $clog2(SLOTS),
	localparam int CntW = $clog2(SLOTS + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  logic            cmd,
	input  logic [IdxW-1:0] slot_index,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output logic            granted,
	output logic [IdxW-1:0] slot,
	output logic [CntW-1:0] used_count,
	output logic            is_full,
	output logic            is_empty,
	output logic            bad_free
);

	state_t          state_q;
	logic            cmd_q;
	logic [IdxW-1:0] addr_q;
	logic            full_q;
	logic [CntW-1:0] count_q;
	logic [IdxW-1:0] scan_q;
	logic            granted_q;
	logic [IdxW-1:0] slot_q;
	logic            bad_q;

	logic            rsp_valid_q;
	logic            rsp_granted_q;
	logic [IdxW-1:0] rsp_slot_q;
	logic [CntW-1:0] rsp_count_q;
	logic            rsp_full_q;
	logic            rsp_empty_q;
	logic            rsp_bad_q;

	cell_ctl_t       ctl;
	logic [SLOTS-1:0] tok_v;
	logic [SLOTS-1:0] hit_v;
	logic [SLOTS-1:0] take_v;
	logic            hit_any;
	logic            take_any;
	logic            load;

	assign hit_any  = |hit_v;
	assign take_any = |take_v;

	assign ctl.wr_en  = (state_q == ST_LOOK) &&
		(((cmd_q == CMD_ALLOC) && !full_q && !hit_any) ||
		 ((cmd_q == CMD_FREE) && hit_any));
	assign ctl.wr_val = (cmd_q == CMD_ALLOC);
	assign ctl.scan   = (state_q == ST_SCAN);

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic tok_in;
		if (i == 0) begin : g_head
			assign tok_in = (scan_q == '0);
		end else begin : g_link
			assign tok_in = tok_v[i-1];
		end
		fsa_cell #(
			.IdxW (IdxW),
			.Idx  (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.addr    (addr_q),
			.tok_in  (tok_in),
			.tok_out (tok_v[i]),
			.hit     (hit_v[i]),
			.take    (take_v[i])
		);
	end

	assign load = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					scan_q <= '0;
					if (cmd_q == CMD_ALLOC) begin
						if (full_q) begin
							state_q <= ST_FIN;
						end else if (!hit_any) begin
							count_q <= count_q + CntW'(1);
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end else begin
						if (hit_any) begin
							count_q <= count_q - CntW'(1);
						end
						state_q <= ST_FIN;
					end
				end
				ST_SCAN: begin
					if (take_any) begin
						count_q <= count_q + CntW'(1);
						state_q <= ST_FIN;
					end else begin
						scan_q <= scan_q + IdxW'(1);
					end
				end
				ST_FIN: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && cmd_valid) begin
			cmd_q  <= cmd;
			addr_q <= (cmd == CMD_FREE) ? slot_index : count_q[IdxW-1:0];
			full_q <= (count_q == CntW'(SLOTS));
		end
		if (state_q == ST_LOOK) begin
			granted_q <= (cmd_q == CMD_ALLOC) && !full_q && !hit_any;
			slot_q    <= ((cmd_q == CMD_ALLOC) && !full_q && !hit_any) ? addr_q : '0;
			bad_q     <= (cmd_q == CMD_FREE) && !hit_any;
		end
		if ((state_q == ST_SCAN) && take_any) begin
			granted_q <= 1'b1;
			slot_q    <= scan_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_granted_q <= granted_q;
			rsp_slot_q    <= slot_q;
			rsp_count_q   <= count_q;
			rsp_full_q    <= (count_q == CntW'(SLOTS));
			rsp_empty_q   <= (count_q == '0);
			rsp_bad_q     <= bad_q;
		end
	end

	assign cmd_stall  = (state_q != ST_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign granted    = rsp_granted_q;
	assign slot       = rsp_slot_q;
	assign used_count = rsp_count_q;
	assign is_full    = rsp_full_q;
	assign is_empty   = rsp_empty_q;
	assign bad_free   = rsp_bad_q;

endmodule

[hdl/fsa_checker.sv]
// port-level checks of the fixed slot allocator and their bind
module fsa_checker import fsa_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int IdxW = $clog2(SLOTS),
	localparam int CntW = $clog2(SLOTS + 1)
) (
	input logic            clk,
	input logic            arst_n,
	input logic            cmd_valid,
	input logic            cmd_stall,
	input logic            cmd,
	input logic [IdxW-1:0] slot_index,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input logic            granted,
	input logic [IdxW-1:0] slot,
	input logic [CntW-1:0] used_count,
	input logic            is_full,
	input logic            is_empty,
	input logic            bad_free
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(slot) && $stable(used_count)
			&& $stable(granted) && $stable(bad_free))
		else $error("stalled response item changed");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_full == (used_count == CntW'(SLOTS))))
		else $error("is_full disagrees with used_count");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (used_count == '0)))
		else $error("is_empty disagrees with used_count");

	a_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !granted |-> (slot == '0))
		else $error("slot nonzero without a grant");

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd) && $stable(slot_index))
		else $error("stalled command item changed");

endmodule

bind fixed_slot_allocator_core fsa_checker #(.SLOTS(SLOTS)) u_fsa_checker (.*);
